[hw/rtl/dger_pkg.sv]
`timescale 1ns / 1ps

package dger_pkg;

    localparam int MAX_POINTS = 128;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 7;
    localparam int D_W        = 7;
    localparam int LAKE_HALF  = 50;
    localparam int DISK_TERM  = 15;
    localparam int OPND_W     = 10;
    localparam int SUM_W      = 2 * OPND_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [D_W-1:0]     t_dist;
    typedef logic signed [OPND_W-1:0]  t_opnd;
    typedef logic        [SUM_W-1:0]   t_sum;
    typedef logic        [IDX_W-1:0]   t_idx;
    typedef logic        [CNT_W-1:0]   t_cnt;

endpackage

[hw/rtl/dger_sq_unit.sv]
`timescale 1ns / 1ps

module dger_sq_unit (
    input  logic            i_clk,
    input  dger_pkg::t_opnd i_a,
    input  dger_pkg::t_opnd i_b,
    output dger_pkg::t_sum  o_sum
);
    import dger_pkg::*;

    logic signed [SUM_W-1:0] w_sq_a;
    logic signed [SUM_W-1:0] w_sq_b;

    assign w_sq_a = i_a * i_a;
    assign w_sq_b = i_b * i_b;

    always_ff @(posedge i_clk) begin
        o_sum <= $unsigned(w_sq_a) + $unsigned(w_sq_b);
    end

endmodule

[hw/rtl/disk_graph_escape_reachability.sv]
`timescale 1ns / 1ps
// Points load one per cycle while o_in_stall is low; a point marked last starts the search
// and the result follows it. Search: limit setup, then per start candidate a read, square,
// compare and next step, per popped point a pop, address and check step and a scan of all
// stored points, then the result is registered. One shared squarer; one-port point memories.
// Reset is synchronous and active low: it clears the sequencer, count, drop flag, visited
// bits and jump distance; the point and stack memories are not cleared.

module disk_graph_escape_reachability (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  dger_pkg::t_dist  i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dger_pkg::t_coord i_x_coord,
    input  dger_pkg::t_coord i_y_coord,
    input  logic             i_last_point,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_reachable,
    output logic             o_overflow
);
    import dger_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_LIM1,
        S_LIM2,
        S_LIM3,
        S_OUTER_RD,
        S_OUTER_SQ,
        S_OUTER_CMP,
        S_NEXT,
        S_POP,
        S_POP_ADDR,
        S_POP_CHK,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                r_state;
    t_dist                 r_jd;
    t_cnt                  r_count;
    logic                  r_drop;
    logic                  r_found;
    logic [MAX_POINTS-1:0] r_visited;
    t_sum                  r_start_lim;
    t_sum                  r_jump_lim;
    t_cnt                  r_s;
    t_cnt                  r_j;
    t_cnt                  r_top;
    logic                  r_v1;
    logic                  r_v2;
    t_idx                  r_j1;
    t_idx                  r_j2;
    t_coord                r_cx;
    t_coord                r_cy;

    t_coord mem_x [MAX_POINTS];
    t_coord mem_y [MAX_POINTS];
    t_idx   mem_stk [MAX_POINTS];
    t_coord r_rdx;
    t_coord r_rdy;
    t_idx   r_stk_rd;

    logic   w_in_accept;
    logic   w_load_we;
    t_idx   w_pt_raddr;
    t_cnt   w_top_dec;
    t_cnt   w_s_inc;
    logic   w_push;
    logic   w_seed;
    logic   w_stk_we;
    t_idx   w_stk_waddr;
    t_idx   w_stk_wdata;
    t_opnd  w_op_a;
    t_opnd  w_op_b;
    t_sum   w_sum;
    logic [COORD_W:0] w_ext_x;
    logic [COORD_W:0] w_ext_y;
    logic [COORD_W:0] w_ax;
    logic [COORD_W:0] w_ay;
    logic   w_exit;
    logic   w_can_put;

    dger_sq_unit u_sq (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_sum (w_sum)
    );

    assign o_in_stall  = (r_state != S_LOAD);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_load_we   = w_in_accept && (r_count < CNT_W'(MAX_POINTS));
    assign w_top_dec   = r_top - CNT_W'(1);
    assign w_s_inc     = r_s + CNT_W'(1);
    assign w_can_put   = !o_out_valid || !i_out_stall;

    assign w_push = (r_state == S_SCAN) && r_v2 && !r_visited[r_j2] &&
                    (w_sum <= r_jump_lim) && (r_top < CNT_W'(MAX_POINTS));
    assign w_seed = (r_state == S_OUTER_CMP) && !r_visited[r_s[IDX_W-1:0]] &&
                    (w_sum <= r_start_lim);
    assign w_stk_we    = w_push || w_seed;
    assign w_stk_waddr = w_seed ? '0 : r_top[IDX_W-1:0];
    assign w_stk_wdata = w_seed ? r_s[IDX_W-1:0] : r_j2;

    assign w_ext_x = {r_rdx[COORD_W-1], r_rdx};
    assign w_ext_y = {r_rdy[COORD_W-1], r_rdy};
    assign w_ax    = r_rdx[COORD_W-1] ? (~w_ext_x + 1'b1) : w_ext_x;
    assign w_ay    = r_rdy[COORD_W-1] ? (~w_ext_y + 1'b1) : w_ext_y;
    assign w_exit  = ((w_ax + {1'b0, r_jd}) >= (COORD_W + 1)'(LAKE_HALF)) ||
                     ((w_ay + {1'b0, r_jd}) >= (COORD_W + 1)'(LAKE_HALF));

    always_comb begin
        case (r_state)
            S_OUTER_RD: w_pt_raddr = r_s[IDX_W-1:0];
            S_POP_ADDR: w_pt_raddr = r_stk_rd;
            S_SCAN:     w_pt_raddr = r_j[IDX_W-1:0];
            default:    w_pt_raddr = '0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_LIM1: begin
                w_op_a = t_opnd'({{(OPND_W-D_W-1){1'b0}}, r_jd, 1'b0}) + t_opnd'(DISK_TERM);
                w_op_b = '0;
            end
            S_LIM2: begin
                w_op_a = t_opnd'({{(OPND_W-D_W){1'b0}}, r_jd});
                w_op_b = '0;
            end
            S_OUTER_SQ: begin
                w_op_a = t_opnd'(r_rdx) <<< 1;
                w_op_b = t_opnd'(r_rdy) <<< 1;
            end
            S_SCAN: begin
                w_op_a = t_opnd'(r_cx) - t_opnd'(r_rdx);
                w_op_b = t_opnd'(r_cy) - t_opnd'(r_rdy);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            mem_x[r_count[IDX_W-1:0]] <= i_x_coord;
            mem_y[r_count[IDX_W-1:0]] <= i_y_coord;
        end
        r_rdx <= mem_x[w_pt_raddr];
        r_rdy <= mem_y[w_pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            mem_stk[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_rd <= mem_stk[w_top_dec[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_jd        <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_found     <= 1'b0;
            r_visited   <= '0;
            r_s         <= '0;
            r_j         <= '0;
            r_top       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_jd <= i_cfg_wr_data;
            end
            if (o_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_accept) begin
                        if (w_load_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_found <= 1'b0;
                            r_state <= S_LIM1;
                        end
                    end
                end
                S_LIM1: begin
                    r_state <= S_LIM2;
                end
                S_LIM2: begin
                    r_start_lim <= w_sum;
                    r_state     <= S_LIM3;
                end
                S_LIM3: begin
                    r_jump_lim <= w_sum;
                    r_s        <= '0;
                    r_state    <= S_OUTER_RD;
                end
                S_OUTER_RD: begin
                    r_state <= S_OUTER_SQ;
                end
                S_OUTER_SQ: begin
                    r_state <= S_OUTER_CMP;
                end
                S_OUTER_CMP: begin
                    if (w_seed) begin
                        r_visited[r_s[IDX_W-1:0]] <= 1'b1;
                        r_top   <= CNT_W'(1);
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (w_s_inc >= r_count) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_s     <= w_s_inc;
                        r_state <= S_OUTER_RD;
                    end
                end
                S_POP: begin
                    r_top   <= w_top_dec;
                    r_state <= S_POP_ADDR;
                end
                S_POP_ADDR: begin
                    r_state <= S_POP_CHK;
                end
                S_POP_CHK: begin
                    if (w_exit) begin
                        r_found <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        r_cx    <= r_rdx;
                        r_cy    <= r_rdy;
                        r_j     <= '0;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_j < r_count) begin
                        r_v1 <= 1'b1;
                        r_j1 <= r_j[IDX_W-1:0];
                        r_j  <= r_j + CNT_W'(1);
                    end else begin
                        r_v1 <= 1'b0;
                    end
                    r_v2 <= r_v1;
                    r_j2 <= r_j1;
                    if (w_push) begin
                        r_visited[r_j2] <= 1'b1;
                        r_top           <= r_top + CNT_W'(1);
                    end
                    if ((r_j >= r_count) && !r_v1 && !r_v2) begin
                        r_state <= (r_top != '0) ? S_POP : S_NEXT;
                    end
                end
                S_FINISH: begin
                    if (w_can_put) begin
                        o_out_valid <= 1'b1;
                        o_reachable <= r_found;
                        o_overflow  <= r_drop;
                        r_count     <= '0;
                        r_drop      <= 1'b0;
                        r_visited   <= '0;
                        r_top       <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // The search never holds more stack entries than stored points.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top <= r_count) && (r_count <= CNT_W'(MAX_POINTS)))
        else $error("stack depth exceeds the stored point count");

    // Finding an exit ends the search at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> (r_state == S_FINISH))
        else $error("exit found without ending the search");

    // A finished set leaves the block clean for the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_FINISH) && (r_state == S_LOAD)
            |-> (r_visited == '0) && (r_count == '0) && !r_drop && o_out_valid)
        else $error("set state not cleared after the result");

endmodule
